/* src/fifo_with_duplicate_diversion_top_macros.svh */
// Assertion macros used by the checker of the duplicate-diverting FIFO.
`ifndef FIFO_WITH_DUPLICATE_DIVERSION_TOP_MACROS_SVH
`define FIFO_WITH_DUPLICATE_DIVERSION_TOP_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define FDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define FDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/fdd_pkg.sv */
// Shared types and codes for the duplicate-diverting FIFO.
package fdd_pkg;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [2:0] ST_MAIN  = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_DEQ   = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data_out;
  } out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

/* src/fifo_with_duplicate_diversion_top.sv */
// Top level of the FIFO that diverts duplicate inserts into a second store.
// The result of an item strobes on the out_ ports in the cycle after it is accepted.
// Throughput: one item per cycle while busy is low; a row of compare cells resolves membership combinationally.
// busy is high during reset and until a clock edge with rst_n high clears it; results cannot be stalled.
// Reset (synchronous, rst_n low): both queues empty, head at the first cell, no strobe.
module fifo_with_duplicate_diversion_top #(
  parameter int MAIN_DEPTH  = 16,
  parameter int DUP_DEPTH   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  fdd_pkg::in_t  in_item,
  output logic          out_strobe,
  output fdd_pkg::out_t out_item
);
  import fdd_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(MAIN_DEPTH + 1);

  // Row of cells: cell 0 is the head; entries sit packed from cell 0 upward.
  cell_ctl_t     cell_ctl   [MAIN_DEPTH];
  logic          cell_valid [MAIN_DEPTH];
  logic [VW-1:0] cell_data  [MAIN_DEPTH];
  logic [MAIN_DEPTH-1:0] cell_match;

  logic          busy_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_strobe_r;
  out_t          out_item_r, out_item_nxt;

  logic          accept, do_ins, do_deq;
  logic          match_any, main_full, dup_full;
  logic          ins_main, ins_dup, deq_ok;
  logic [VW+31:0] in_ext;
  logic [VW-1:0]  ins_value;
  logic [VW+31:0] head_ext;

  assign accept = start && !busy_r;
  assign do_ins = accept && (in_item.action == ACT_INSERT);
  assign do_deq = accept && (in_item.action == ACT_DEQUEUE);

  // Keep the low VALUE_WIDTH bits of the input, zero-filling when wider.
  assign in_ext    = {{VW{1'b0}}, in_item.value};
  assign ins_value = in_ext[VW-1:0];

  assign match_any = |cell_match;
  assign main_full = (count_r == CW'(MAIN_DEPTH));

  assign ins_main = do_ins && !match_any && !main_full;
  assign ins_dup  = do_ins && match_any && !dup_full;
  assign deq_ok   = do_deq && (count_r != '0);

  genvar gi;
  generate
    for (gi = 0; gi < MAIN_DEPTH; gi++) begin : g_cell
      logic          nb_valid;
      logic [VW-1:0] nb_data;

      // Advance toward the head on dequeue; the last cell takes an empty slot.
      if (gi == MAIN_DEPTH - 1) begin : g_last
        assign nb_valid = 1'b0;
        assign nb_data  = '0;
      end else begin : g_mid
        assign nb_valid = cell_valid[gi+1];
        assign nb_data  = cell_data[gi+1];
      end

      // Load the tail cell, which sits at the current fill count.
      assign cell_ctl[gi].shift = deq_ok;
      assign cell_ctl[gi].load  = ins_main && (count_r == CW'(gi));

      fdd_cell #(.W(VW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cell_ctl[gi]),
        .load_data  (ins_value),
        .next_valid (nb_valid),
        .next_data  (nb_data),
        .cmp_data   (ins_value),
        .valid      (cell_valid[gi]),
        .data       (cell_data[gi]),
        .match      (cell_match[gi])
      );
    end
  endgenerate

  fdd_dup_store #(.DEPTH(DUP_DEPTH), .W(VW)) u_dup (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ins_dup),
    .wr_data (ins_value),
    .full    (dup_full)
  );

  // Sign-extend the head entry from VALUE_WIDTH bits for the result.
  assign head_ext = {{32{cell_data[0][VW-1]}}, cell_data[0]};

  always_comb begin
    count_nxt = count_r;
    if (ins_main) begin
      count_nxt = count_r + CW'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_item_nxt.data_out = '0;
    priority if (do_deq) begin
      if (deq_ok) begin
        out_item_nxt.status   = ST_DEQ;
        out_item_nxt.data_out = head_ext[31:0];
      end else begin
        out_item_nxt.status = ST_EMPTY;
      end
    end else if (ins_main) begin
      out_item_nxt.status = ST_MAIN;
    end else if (ins_dup) begin
      out_item_nxt.status = ST_DUP;
    end else begin
      // Drop an insert whose target queue is full.
      out_item_nxt.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  // Hold the result payload; it is only looked at while the strobe is high.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

/* src/fdd_cell.sv */
// One storage cell of the main queue: holds an entry, compares it, hands it toward the head.
module fdd_cell #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fdd_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       load_data,
  input  logic               next_valid,
  input  logic [W-1:0]       next_data,
  input  logic [W-1:0]       cmp_data,
  output logic               valid,
  output logic [W-1:0]       data,
  output logic               match
);
  import fdd_pkg::*;

  logic         valid_r, valid_nxt;
  logic [W-1:0] data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    priority if (ctl.shift) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else if (ctl.load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else begin
      // Hold the entry.
      valid_nxt = valid_r;
      data_nxt  = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign match = valid_r && (data_r == cmp_data);

endmodule

/* src/fdd_dup_store.sv */
// Append-only store for diverted duplicate values, with its fill count.
module fdd_dup_store #(
  parameter int DEPTH = 16,
  parameter int W     = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full
);
  import fdd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign count_nxt = wr_en ? count_r + CW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Write at the fill count; the caller never writes when full.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
  end

endmodule

/* src/fdd_checker.sv */
// Port-level checker for the duplicate-diverting FIFO, bound to the top level.
`include "fifo_with_duplicate_diversion_top_macros.svh"

module fdd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input fdd_pkg::in_t  in_item,
  input logic          out_strobe,
  input fdd_pkg::out_t out_item
);
  import fdd_pkg::*;

  `FDD_ASSERT_NEXT(a_result_follows, start && !busy, out_strobe, "accepted item gave no result")
  `FDD_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !out_strobe, "result without an item")
  `FDD_ASSERT_NOW(a_data_zero, out_strobe && (out_item.status != ST_DEQ), out_item.data_out == '0, "nonzero data without dequeue")
  `FDD_ASSERT_NEXT(a_insert_status, start && !busy && (in_item.action == ACT_INSERT), (out_item.status == ST_MAIN) || (out_item.status == ST_DUP) || (out_item.status == ST_FULL), "bad insert status")

endmodule

bind fifo_with_duplicate_diversion_top fdd_checker u_fdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
